### hw/rtl/at_command_mask_toggler_defines.svh
// ----------------------------------------------------------------------------
// at_command_mask_toggler_defines.svh
// Assertion macros shared by the AT command mask toggler RTL
// ----------------------------------------------------------------------------
`ifndef AT_COMMAND_MASK_TOGGLER_DEFINES_SVH
`define AT_COMMAND_MASK_TOGGLER_DEFINES_SVH

// same-cycle implication, clocked on clk, quiet while arst_n is low
`define ATCMT_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, quiet while arst_n is low
`define ATCMT_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/atcmt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atcmt_pkg
// Types and constants of the AT command mask toggler
// ----------------------------------------------------------------------------
package atcmt_pkg;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned MASK_W   = 32;
	localparam int unsigned LINE_MAX = 32;
	localparam int unsigned LEN_W    = 6;
	localparam int unsigned BIT_W    = 5;

	// character codes
	localparam logic [BYTE_W-1:0] CH_LF    = 8'd10;
	localparam logic [BYTE_W-1:0] CH_CR    = 8'd13;
	localparam logic [BYTE_W-1:0] CH_A     = 8'h41;
	localparam logic [BYTE_W-1:0] CH_T     = 8'h54;
	localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

	localparam logic [LEN_W-1:0] PREFIX_LEN = 6'd3;
	localparam logic [LEN_W-1:0] MIN_LEN    = 6'd4;

	// one result word
	typedef struct packed {
		logic [MASK_W-1:0] mask;
		logic              executed;
		logic              overflow;
	} res_t;

	// expected character at each prefix position
	function automatic logic [BYTE_W-1:0] prefix_char(input logic [1:0] pos);
		logic [BYTE_W-1:0] c;
		unique case (pos)
			2'd0:    c = CH_A;
			2'd1:    c = CH_T;
			default: c = CH_PLUS;
		endcase
		return c;
	endfunction

endpackage

### hw/rtl/atcmt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atcmt_if
// Handshake channels of the AT command mask toggler
// ----------------------------------------------------------------------------

// received byte channel
interface atcmt_rx_if import atcmt_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;
	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

// result channel
interface atcmt_res_if import atcmt_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [MASK_W-1:0] enable_mask;
	logic              line_executed;
	logic              overflow_discard;
	modport source (output valid, output enable_mask, output line_executed,
		output overflow_discard, input ready);
	modport sink   (input valid, input enable_mask, input line_executed,
		input overflow_discard, output ready);
endinterface

// off id write channel
interface atcmt_cfg_if import atcmt_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] off_id;
	modport source (output valid, output off_id, input ready);
	modport sink   (input valid, input off_id, output ready);
endinterface

### hw/rtl/at_command_mask_toggler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// at_command_mask_toggler
// Gathers AT+ command lines byte by byte and toggles bits of an enable mask
// ----------------------------------------------------------------------------
// channel  dir  payload                                        handshake
// rx       in   rx_byte[7:0]                                   valid/ready
// cfg      in   off_id[7:0]                                    valid/ready
// res      out  enable_mask[31:0], line_executed, overflow     valid/ready
//
// one byte per cycle sustained while res.ready stays high; the result word is
// registered (input register, then result register)
// reset clears the line state, the mask and off_id to zero (prefix flag set)
// a stalled result holds the input register; rx.ready drops only when both
// the input register and the result register are full and res.ready is low
module at_command_mask_toggler import atcmt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	atcmt_rx_if.sink    rx,
	atcmt_cfg_if.sink   cfg,
	atcmt_res_if.source res
);

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              can_load;
	logic              step;
	res_t              result;

	assign step     = valid_s1 && can_load;
	assign rx.ready = !valid_s1 || can_load;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.valid && rx.ready) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	// line parser and mask state
	atcmt_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.step    (step),
		.byte_s1 (byte_s1),
		.result  (result)
	);

	// result register
	atcmt_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (step),
		.d        (result),
		.can_load (can_load),
		.res      (res)
	);

endmodule

### hw/rtl/atcmt_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atcmt_core
// Line state, number parsing and mask update for one byte per step
// ----------------------------------------------------------------------------
`include "at_command_mask_toggler_defines.svh"

module atcmt_core import atcmt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	atcmt_cfg_if.sink         cfg,
	input  logic              step,
	input  logic [BYTE_W-1:0] byte_s1,
	output res_t              result
);

	logic [LEN_W-1:0]  len_q, len_d;
	logic              prefix_ok_q, prefix_ok_d;
	logic [BYTE_W-1:0] acc_q, acc_d;
	logic              in_num_q, in_num_d;
	logic              pclear_q, pclear_d;
	logic [MASK_W-1:0] ptog_q, ptog_d;
	logic [MASK_W-1:0] mask_q, mask_d;
	logic [BYTE_W-1:0] off_id_q;

	logic              is_term;
	logic              is_digit;
	logic              n_is_off;
	logic              fin_clear;
	logic [MASK_W-1:0] fin_tog;
	logic              end_clear;
	logic [MASK_W-1:0] end_tog;
	logic [BYTE_W-1:0] acc_x10;

	// config register, always ready
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_id_q <= '0;
		end else if (cfg.valid) begin
			off_id_q <= cfg.off_id;
		end
	end

	// byte classes and number completion
	always_comb begin
		is_term   = (byte_s1 == CH_LF) || (byte_s1 == CH_CR);
		is_digit  = (byte_s1 >= CH_ZERO) && (byte_s1 <= CH_NINE);
		acc_x10   = BYTE_W'({acc_q, 3'b000}) + BYTE_W'({acc_q, 1'b0});
		n_is_off  = (acc_q == off_id_q);
		fin_clear = pclear_q || n_is_off;
		if (n_is_off) begin
			fin_tog = '0;
		end else if (acc_q[BYTE_W-1:BIT_W] == '0) begin
			fin_tog = ptog_q ^ (MASK_W'(1) << acc_q[BIT_W-1:0]);
		end else begin
			fin_tog = ptog_q;
		end
		end_clear = in_num_q ? fin_clear : pclear_q;
		end_tog   = in_num_q ? fin_tog : ptog_q;
	end

	// next state for one byte
	always_comb begin
		len_d       = len_q;
		prefix_ok_d = prefix_ok_q;
		acc_d       = acc_q;
		in_num_d    = in_num_q;
		pclear_d    = pclear_q;
		ptog_d      = ptog_q;
		mask_d      = mask_q;
		result.executed = 1'b0;
		result.overflow = 1'b0;
		if (is_term) begin
			if (len_q != '0) begin
				if ((len_q >= MIN_LEN) && prefix_ok_q) begin
					mask_d = end_clear ? end_tog : (mask_q ^ end_tog);
					result.executed = 1'b1;
				end
				len_d       = '0;
				prefix_ok_d = 1'b1;
				acc_d       = '0;
				in_num_d    = 1'b0;
				pclear_d    = 1'b0;
				ptog_d      = '0;
			end
		end else if (len_q < LEN_W'(LINE_MAX)) begin
			if (len_q < PREFIX_LEN) begin
				if (byte_s1 != prefix_char(len_q[1:0])) begin
					prefix_ok_d = 1'b0;
				end
			end else if (is_digit) begin
				acc_d    = acc_x10 + (byte_s1 - CH_ZERO);
				in_num_d = 1'b1;
			end else if (in_num_q) begin
				pclear_d = fin_clear;
				ptog_d   = fin_tog;
				acc_d    = '0;
				in_num_d = 1'b0;
			end
			len_d = len_q + 6'd1;
		end else begin
			len_d       = '0;
			prefix_ok_d = 1'b1;
			acc_d       = '0;
			in_num_d    = 1'b0;
			pclear_d    = 1'b0;
			ptog_d      = '0;
			result.overflow = 1'b1;
		end
		result.mask = mask_d;
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			prefix_ok_q <= 1'b1;
			acc_q       <= '0;
			in_num_q    <= 1'b0;
			pclear_q    <= 1'b0;
			ptog_q      <= '0;
			mask_q      <= '0;
		end else if (step) begin
			len_q       <= len_d;
			prefix_ok_q <= prefix_ok_d;
			acc_q       <= acc_d;
			in_num_q    <= in_num_d;
			pclear_q    <= pclear_d;
			ptog_q      <= ptog_d;
			mask_q      <= mask_d;
		end
	end

	// checks
	`ATCMT_ASSERT_IMP(a_exec_xor_ovf, step, !(result.executed && result.overflow), "executed and overflow together")
	`ATCMT_ASSERT_NXT(a_ovf_clears, step && result.overflow, (len_q == '0) && !in_num_q && (ptog_q == '0), "overflow left line state")
	`ATCMT_ASSERT_NXT(a_len_count, step && !is_term && (len_q < LEN_W'(LINE_MAX)), len_q == $past(len_q) + 6'd1, "line length did not advance")
	`ATCMT_ASSERT_NXT(a_mask_hold, !step, $stable(mask_q), "mask changed without a byte")

endmodule

### hw/rtl/atcmt_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atcmt_out_reg
// Result register driving the result channel
// ----------------------------------------------------------------------------
module atcmt_out_reg import atcmt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  res_t       d,
	output logic       can_load,
	atcmt_res_if.source res
);

	logic valid_q;
	res_t data_q;

	// free when empty or when the held word leaves this cycle
	assign can_load = !valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (res.ready) begin
			valid_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= d;
		end
	end

	assign res.valid            = valid_q;
	assign res.enable_mask      = data_q.mask;
	assign res.line_executed    = data_q.executed;
	assign res.overflow_discard = data_q.overflow;

endmodule

### dv/at_command_mask_toggler_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// at_command_mask_toggler_test
// Self-checking bench for the AT command mask toggler. Command bytes and
// off id writes go in through the handshake channels, a line parser of the
// bench's own predicts every result word, and each word that comes out is
// compared field by field in arrival order. Directed lines cover framing,
// number rules and an off id change inside a line. Random command lines,
// noise and over-long lines follow, under random sender gaps, receiver
// stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
module at_command_mask_toggler_test;
	import atcmt_pkg::*;

	localparam int unsigned MAX_CYCLES   = 300000;
	localparam int unsigned RANDOM_WORDS = 1600;
	localparam int unsigned PHASES       = 8;
	localparam int unsigned HOLD_CYCLES  = 300;

	localparam logic [BYTE_W-1:0] SEP_COMMA = 8'h2C;
	localparam logic [BYTE_W-1:0] SEP_SPACE = 8'h20;
	localparam logic [BYTE_W-1:0] CH_NUL    = 8'h00;
	localparam logic [BYTE_W-1:0] CH_HIGH   = 8'hFF;

	logic clk;
	logic arst_n;

	atcmt_rx_if  rx_ch();
	atcmt_cfg_if cfg_ch();
	atcmt_res_if res_ch();

	at_command_mask_toggler dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.cfg    (cfg_ch),
		.res    (res_ch)
	);

	// mirror of the line parser state
	logic [BYTE_W-1:0] off_id_q;
	logic [LEN_W-1:0]  line_len;
	logic              prefix_good;
	logic [BYTE_W-1:0] num_acc;
	logic              in_num;
	logic              pend_clear;
	logic [MASK_W-1:0] pend_xor;
	logic [MASK_W-1:0] mask_q;

	res_t              due_results[$];
	res_t              want;
	logic [BYTE_W-1:0] line_buf[$];

	int mismatches    = 0;
	int cycle_count   = 0;
	int words_sent    = 0;
	int burst_left    = 0;
	bit sender_steady = 1'b0;
	int hold_request  = 0;

	int          hold_left;
	int          pattern_age;
	logic [15:0] stall_pattern;

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// forget the line in progress
	function automatic void restart_line();
		line_len    = '0;
		prefix_good = 1'b1;
		num_acc     = '0;
		in_num      = 1'b0;
		pend_clear  = 1'b0;
		pend_xor    = '0;
	endfunction

	// a finished number clears, toggles one bit, or (32 and above) is ignored
	function automatic void close_number();
		if (num_acc == off_id_q) begin
			pend_clear = 1'b1;
			pend_xor   = '0;
		end else if (num_acc < MASK_W) begin
			pend_xor ^= (32'd1 << num_acc[BIT_W-1:0]);
		end
		num_acc = '0;
		in_num  = 1'b0;
	endfunction

	// advance the parser by one byte and return the word it yields
	function automatic res_t parse_rx_byte(input logic [BYTE_W-1:0] b);
		res_t r;
		r.executed = 1'b0;
		r.overflow = 1'b0;
		if (b == CH_LF || b == CH_CR) begin
			if (line_len != 0) begin
				if (line_len >= MIN_LEN && prefix_good) begin
					if (in_num)
						close_number();
					if (pend_clear)
						mask_q = pend_xor;
					else
						mask_q ^= pend_xor;
					r.executed = 1'b1;
				end
				restart_line();
			end
		end else if (line_len < LINE_MAX) begin
			if (line_len < PREFIX_LEN) begin
				case (line_len[1:0])
					2'd0: if (b != CH_A) prefix_good = 1'b0;
					2'd1: if (b != CH_T) prefix_good = 1'b0;
					default: if (b != CH_PLUS) prefix_good = 1'b0;
				endcase
			end else if (b >= CH_ZERO && b <= CH_NINE) begin
				num_acc = num_acc * 8'd10 + (b - CH_ZERO);
				in_num  = 1'b1;
			end else if (in_num) begin
				close_number();
			end
			line_len++;
		end else begin
			restart_line();
			r.overflow = 1'b1;
		end
		r.mask = mask_q;
		return r;
	endfunction

	// any byte that is neither a digit nor a line end
	function automatic logic [BYTE_W-1:0] pick_separator();
		logic [BYTE_W-1:0] c;
		case ($urandom_range(0, 3))
			0: c = SEP_COMMA;
			1: c = SEP_SPACE;
			default: begin
				do c = BYTE_W'($urandom_range(0, 255));
				while ((c >= CH_ZERO && c <= CH_NINE) || c == CH_LF || c == CH_CR);
			end
		endcase
		return c;
	endfunction

	function automatic void start_command();
		line_buf.delete();
		line_buf.push_back(CH_A);
		line_buf.push_back(CH_T);
		line_buf.push_back(CH_PLUS);
	endfunction

	// offer one byte in bursts with random gaps, then predict its word
	task automatic send_byte(input logic [BYTE_W-1:0] b);
		int gap;
		if (burst_left == 0) begin
			gap = (sender_steady || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			burst_left = $urandom_range(1, 24);
			if (gap > 0) begin
				rx_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		rx_ch.valid   <= 1'b1;
		rx_ch.rx_byte <= b;
		do @(posedge clk); while (!rx_ch.ready);
		due_results.push_back(parse_rx_byte(b));
		words_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	task automatic flush_line();
		foreach (line_buf[i])
			send_byte(line_buf[i]);
		line_buf.delete();
	endtask

	// stop offering and wait until every expected word has come back
	task automatic drain_results();
		rx_ch.valid <= 1'b0;
		do @(posedge clk); while (due_results.size() != 0);
	endtask

	task automatic write_off_id(input logic [BYTE_W-1:0] v);
		drain_results();
		cfg_ch.valid  <= 1'b1;
		cfg_ch.off_id <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		off_id_q = v;
		cfg_ch.valid <= 1'b0;
	endtask

	// well-formed command line with random numbers, optionally a broken prefix
	task automatic send_command_line(input bit corrupt);
		int    target;
		int    value;
		string digits;
		start_command();
		target = ($urandom_range(0, 7) == 0) ? $urandom_range(LINE_MAX - 4, LINE_MAX + 8)
			: $urandom_range(4, 24);
		while (line_buf.size() < target) begin
			case ($urandom_range(0, 5))
				0: value = off_id_q;
				4: value = $urandom_range(0, 999);
				5: value = off_id_q + 256;
				default: value = $urandom_range(0, MASK_W - 1);
			endcase
			digits = $sformatf("%0d", value);
			if ($urandom_range(0, 7) == 0)
				digits = {"0", digits};
			for (int i = 0; i < digits.len(); i++)
				line_buf.push_back(digits[i]);
			line_buf.push_back(pick_separator());
		end
		// half the lines end while a number is still open
		if ($urandom_range(0, 1) == 1)
			void'(line_buf.pop_back());
		if (corrupt)
			line_buf[$urandom_range(0, 2)] = pick_separator();
		line_buf.push_back($urandom_range(0, 1) ? CH_LF : CH_CR);
		if ($urandom_range(0, 9) == 0)
			line_buf.push_back(CH_CR);
		flush_line();
	endtask

	// raw bytes; without line ends a terminator is added at the tail
	task automatic send_noise_line(input int count, input bit any_byte);
		logic [BYTE_W-1:0] c;
		for (int i = 0; i < count; i++) begin
			if (any_byte)
				c = BYTE_W'($urandom_range(0, 255));
			else
				do c = BYTE_W'($urandom_range(0, 255)); while (c == CH_LF || c == CH_CR);
			line_buf.push_back(c);
		end
		if (!any_byte)
			line_buf.push_back(CH_LF);
		flush_line();
	endtask

	// short line, empty line and a bad prefix
	task automatic test_line_framing();
		send_text("AT+");
		send_byte(CH_CR);
		send_byte(CH_LF);
		send_text("AT");
		send_byte(CH_NUL);
		send_text("1");
		send_byte(CH_LF);
	endtask

	// reset off id of zero clears, 287 wraps to bit 31, number closed by the terminator
	task automatic test_number_rules();
		send_text("AT+0 287");
		send_byte(CH_CR);
	endtask

	// the open number is compared with the off id written mid-line
	task automatic test_off_id_mid_line();
		send_text("AT+0");
		send_byte(CH_HIGH);
		send_text("3");
		write_off_id(8'd3);
		send_byte(CH_LF);
	endtask

	// exactly full line runs, one byte more overflows
	task automatic test_line_overflow();
		for (int extra = 0; extra < 2; extra++) begin
			start_command();
			for (int i = 0; i < LINE_MAX - PREFIX_LEN + extra; i++)
				line_buf.push_back(BYTE_W'($urandom_range(CH_ZERO, CH_NINE)));
			line_buf.push_back(CH_LF);
			flush_line();
		end
		send_noise_line(LINE_MAX + 5, 1'b0);
	endtask

	// long receiver hold-off while the sender keeps offering
	task automatic test_backpressure();
		int stop_at;
		sender_steady = 1'b1;
		hold_request  = HOLD_CYCLES;
		stop_at       = words_sent + 48;
		while (words_sent < stop_at)
			send_command_line(1'b0);
		drain_results();
		sender_steady = 1'b0;
	endtask

	// phases of random traffic, each under its own off id
	task automatic test_random_traffic();
		int phase_end;
		int pick;
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: write_off_id(8'd0);
				1: write_off_id(8'd255);
				2: write_off_id(BYTE_W'($urandom_range(0, MASK_W - 1)));
				3: write_off_id(BYTE_W'($urandom_range(MASK_W, 254)));
				default: write_off_id(BYTE_W'($urandom_range(0, 255)));
			endcase
			sender_steady = (phase % 3 == 1);
			phase_end     = words_sent + RANDOM_WORDS / PHASES;
			while (words_sent < phase_end) begin
				pick = $urandom_range(0, 9);
				if (pick <= 6)
					send_command_line(1'b0);
				else if (pick == 7)
					send_command_line(1'b1);
				else if (pick == 8)
					send_noise_line($urandom_range(LINE_MAX + 1, LINE_MAX + 8), 1'b0);
				else
					send_noise_line($urandom_range(1, 8), 1'b1);
			end
		end
		sender_steady = 1'b0;
	endtask

	// receiver: rotating stall pattern, re-drawn now and then, plus hold-off
	initial begin
		res_ch.ready <= 1'b0;
		hold_left     = 0;
		pattern_age   = 0;
		stall_pattern = 16'hFFFF;
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				hold_left    = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else begin
				if (pattern_age == 0) begin
					pattern_age   = $urandom_range(16, 96);
					stall_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
				end
				pattern_age--;
				stall_pattern = {stall_pattern[14:0], stall_pattern[15]};
				res_ch.ready <= stall_pattern[0];
			end
		end
	end

	// compare each result word with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (due_results.size() == 0) begin
				$error("unexpected word: enable_mask %h line_executed %b overflow_discard %b",
					res_ch.enable_mask, res_ch.line_executed, res_ch.overflow_discard);
				mismatches++;
			end else begin
				want = due_results.pop_front();
				if (res_ch.enable_mask !== want.mask) begin
					$error("enable_mask: expected %h, actual %h", want.mask, res_ch.enable_mask);
					mismatches++;
				end
				if (res_ch.line_executed !== want.executed) begin
					$error("line_executed: expected %b, actual %b", want.executed,
						res_ch.line_executed);
					mismatches++;
				end
				if (res_ch.overflow_discard !== want.overflow) begin
					$error("overflow_discard: expected %b, actual %b", want.overflow,
						res_ch.overflow_discard);
					mismatches++;
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > MAX_CYCLES) begin
			$display("at_command_mask_toggler_test: errors");
			$finish;
		end
	end

	// test sequence
	initial begin
		rx_ch.valid   <= 1'b0;
		rx_ch.rx_byte <= '0;
		cfg_ch.valid  <= 1'b0;
		cfg_ch.off_id <= '0;
		arst_n        <= 1'b0;
		off_id_q = '0;
		mask_q   = '0;
		restart_line();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_line_framing();
		test_number_rules();
		test_off_id_mid_line();
		test_line_overflow();
		test_backpressure();
		test_random_traffic();

		drain_results();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("at_command_mask_toggler_test: clean");
		else
			$display("at_command_mask_toggler_test: errors");
		$finish;
	end

endmodule
